// ----- rtl/mbs_pkg.sv -----
// Shared types and constants for the multi bit-set engine.
package mbs_pkg;

  // Field widths fixed by the interface
  localparam int OpW      = 3;
  localparam int SelW     = 2;
  localparam int BitIdxW  = 12;
  localparam int LenW     = 11;
  localparam int CfgIdxW  = 4;

  // Length registers
  localparam int LenRegs  = 4;
  localparam int LenSelW  = 2;
  localparam logic [LenW-1:0] LenReset = 11'd1024;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_INSERT    = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_MEMBER    = 3'd2,
    OP_FIRST     = 3'd3,
    OP_COPY      = 3'd4,
    OP_UNION     = 3'd5,
    OP_INTERSECT = 3'd6,
    OP_EQUAL     = 3'd7
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_BIT_RD,
    S_BIT_WR,
    S_SCAN,
    S_RESULT
  } state_e;

endpackage

// ----- rtl/mbs_ram.sv -----
// Generic word RAM: one write port, two read ports, registered read data.
module mbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write one word, read two words
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- rtl/multi_bitset_engine.sv -----
// Top level of the multi bit-set engine: sequencer around a word memory.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_ready_o | op, target_set, source_a, source_b, bit_index
//  out     | output    | out_valid_o/out_ready_i | ok, first_index
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Insert, remove and member pass through decode, a bit read and a bit write or check before the
// result state; a failed check goes from decode straight to the result state. Copy, union,
// intersect, first and equal scan n = ceil(length / WORD_BITS) words, up to 32 words at defaults,
// one word per cycle through the memory's two read ports. The next beat can be taken in the same
// cycle as the result appears. After reset the memory is cleared one word a cycle, all NUM_SETS *
// ceil(MAX_BITS / WORD_BITS) words (128 at defaults), while in_ready_o stays low; cfg beats are
// taken throughout. One item is in flight at a time; a finished result waits in the output
// register while the next item is accepted, and a full output register stalls the sequencer.
module multi_bitset_engine
  import mbs_pkg::*;
#(
  parameter int NUM_SETS  = 4,
  parameter int MAX_BITS  = 1024,
  parameter int WORD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // item input
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [OpW-1:0]          op_i,
  input  logic [SelW-1:0]         target_set_i,
  input  logic [SelW-1:0]         source_a_i,
  input  logic [SelW-1:0]         source_b_i,
  input  logic [BitIdxW-1:0]      bit_index_i,
  // result output
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    ok_o,
  output logic signed [LenW-1:0]  first_index_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [LenW-1:0]         cfg_data_i
);

  localparam int WordsPerSet = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int Depth       = NUM_SETS * WordsPerSet;
  localparam int AddrW       = $clog2(Depth);
  localparam int CntW        = $clog2(WordsPerSet + 1);
  localparam int PosW        = $clog2(WORD_BITS);

  // Word address of word w in set s
  function automatic logic [AddrW-1:0] addr_of(input logic [SelW-1:0] s,
                                               input int unsigned w);
    int unsigned a;
    a = 32'(s) * WordsPerSet + w;
    return AddrW'(a);
  endfunction

  // Length register value clamped to MAX_BITS
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] l);
    logic [LenW-1:0] r;
    r = l;
    if (32'(l) > MAX_BITS) r = LenW'(MAX_BITS);
    return r;
  endfunction

  // Number of words a length covers
  function automatic logic [CntW-1:0] words_of(input logic [LenW-1:0] l);
    int unsigned n;
    n = (32'(l) + WORD_BITS - 1) >> PosW;
    return CntW'(n);
  endfunction

  // Mask of valid bit positions in word w of a set of length l
  function automatic logic [WORD_BITS-1:0] valid_mask(input logic [LenW-1:0] l,
                                                      input logic [CntW-1:0] w);
    int unsigned base;
    int unsigned rem;
    logic [WORD_BITS-1:0] m;
    base = 32'(w) << PosW;
    rem  = 0;
    if (32'(l) >= base + WORD_BITS) begin
      m = '1;
    end else if (32'(l) <= base) begin
      m = '0;
    end else begin
      rem = 32'(l) - base;
      m   = (WORD_BITS'(1) << rem) - WORD_BITS'(1);
    end
    return m;
  endfunction

  // Position of the lowest set bit
  function automatic logic [PosW-1:0] ffs(input logic [WORD_BITS-1:0] v);
    logic [PosW-1:0] k;
    k = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) k = PosW'(i);
    end
    return k;
  endfunction

  state_e state_q, state_d;

  logic [LenW-1:0]    len_q [LenRegs];
  logic [LenW-1:0]    len_d [LenRegs];

  op_e                op_q, op_d;
  logic [SelW-1:0]    t_q, t_d, a_q, a_d, b_q, b_d;
  logic [BitIdxW-1:0] bit_q, bit_d;

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [CntW-1:0]    pw_q, pw_d;
  logic               pend_q, pend_d;
  logic [LenW-1:0]    lenw_q, lenw_d;
  logic               ok_q, ok_d;
  logic [LenW-1:0]    first_q, first_d;

  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_ok_d;
  logic [LenW-1:0]    out_first_q, out_first_d;

  logic [AddrW-1:0]   clr_q, clr_d;

  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [WORD_BITS-1:0] ram_wdata, rdata_a, rdata_b;

  logic                 t_ok, a_ok, b_ok;
  logic [LenW-1:0]      lt, la, lb;
  logic                 issue;
  logic [SelW-1:0]      scan_src;
  logic [WORD_BITS-1:0] mask, bit_mask, fv;

  mbs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Set lengths of the captured selectors
  always_comb begin
    t_ok = 32'(t_q) < NUM_SETS;
    a_ok = 32'(a_q) < NUM_SETS;
    b_ok = 32'(b_q) < NUM_SETS;
    lt   = t_ok ? eff_len(len_q[t_q]) : '0;
    la   = a_ok ? eff_len(len_q[a_q]) : '0;
    lb   = b_ok ? eff_len(len_q[b_q]) : '0;
  end

  // Word-level datapath terms
  assign issue    = cnt_q < n_q;
  assign scan_src = (op_q == OP_FIRST) ? t_q : a_q;
  assign mask     = valid_mask(lenw_q, pw_q);
  assign bit_mask = WORD_BITS'(1) << bit_q[PosW-1:0];
  assign fv       = rdata_a & mask;

  // Sequencer: next state, datapath updates and memory controls
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    op_d        = op_q;
    t_d         = t_q;
    a_d         = a_q;
    b_d         = b_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    pw_d        = pw_q;
    pend_d      = pend_q;
    lenw_d      = lenw_q;
    ok_d        = ok_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ok_d    = out_ok_q;
    out_first_d = out_first_q;
    clr_d       = clr_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr_a = '0;
    ram_raddr_b = '0;
    in_ready_o  = 1'b0;

    // take a length register write
    if (cfg_valid_i && (32'(cfg_index_i) < LenRegs)) begin
      len_d[cfg_index_i[LenSelW-1:0]] = cfg_data_i;
    end

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) state_d = S_IDLE;
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          t_d     = target_set_i;
          a_d     = source_a_i;
          b_d     = source_b_i;
          bit_d   = bit_index_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        cnt_d   = '0;
        pend_d  = 1'b0;
        ok_d    = 1'b0;
        first_d = '0;
        lenw_d  = lt;
        n_d     = '0;
        state_d = S_RESULT;
        case (op_q)
          OP_INSERT, OP_REMOVE, OP_MEMBER: begin
            if (t_ok && (bit_q < {1'b0, lt})) state_d = S_BIT_RD;
          end
          OP_FIRST: begin
            first_d = '1;
            n_d     = words_of(lt);
            state_d = S_SCAN;
          end
          OP_COPY: begin
            if (t_ok && a_ok && (lt == la)) begin
              ok_d    = 1'b1;
              n_d     = words_of(lt);
              state_d = S_SCAN;
            end
          end
          OP_UNION, OP_INTERSECT: begin
            if (t_ok && a_ok && b_ok && (lt == la) && (lt == lb)) begin
              ok_d    = 1'b1;
              n_d     = words_of(lt);
              state_d = S_SCAN;
            end
          end
          OP_EQUAL: begin
            if (a_ok && b_ok && (la == lb)) begin
              ok_d    = 1'b1;
              lenw_d  = la;
              n_d     = words_of(la);
              state_d = S_SCAN;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end

      S_BIT_RD: begin
        ram_raddr_a = addr_of(t_q, 32'(bit_q >> PosW));
        state_d     = S_BIT_WR;
      end

      S_BIT_WR: begin
        ram_waddr = addr_of(t_q, 32'(bit_q >> PosW));
        case (op_q)
          OP_INSERT: begin
            ram_we    = 1'b1;
            ram_wdata = rdata_a | bit_mask;
            ok_d      = 1'b1;
          end
          OP_REMOVE: begin
            ram_we    = 1'b1;
            ram_wdata = rdata_a & ~bit_mask;
            ok_d      = 1'b1;
          end
          default: ok_d = |(rdata_a & bit_mask);
        endcase
        state_d = S_RESULT;
      end

      S_SCAN: begin
        // issue the next word read
        ram_raddr_a = addr_of(scan_src, 32'(cnt_q));
        ram_raddr_b = addr_of(b_q, 32'(cnt_q));
        if (issue) cnt_d = cnt_q + CntW'(1);
        pend_d = issue;
        pw_d   = cnt_q;
        // process the word read last cycle
        if (pend_q) begin
          ram_waddr = addr_of(t_q, 32'(pw_q));
          case (op_q)
            OP_COPY: begin
              ram_we    = 1'b1;
              ram_wdata = rdata_a;
            end
            OP_UNION: begin
              ram_we    = 1'b1;
              ram_wdata = rdata_a | rdata_b;
            end
            OP_INTERSECT: begin
              ram_we    = 1'b1;
              ram_wdata = rdata_a & rdata_b;
            end
            OP_FIRST: begin
              if ((|fv) && !ok_q) begin
                ok_d    = 1'b1;
                first_d = LenW'((32'(pw_q) << PosW) + 32'(ffs(fv)));
              end
            end
            OP_EQUAL: begin
              if ((rdata_a & mask) != (rdata_b & mask)) ok_d = 1'b0;
            end
            default: ram_we = 1'b0;
          endcase
        end
        if (!issue && !pend_q) state_d = S_RESULT;
      end

      S_RESULT: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_ok_d    = ok_q;
          out_first_d = first_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LenRegs; i++) len_q[i] <= LenReset;
      clr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    t_q         <= t_d;
    a_q         <= a_d;
    b_q         <= b_d;
    bit_q       <= bit_d;
    n_q         <= n_d;
    pw_q        <= pw_d;
    lenw_q      <= lenw_d;
    ok_q        <= ok_d;
    first_q     <= first_d;
    out_ok_q    <= out_ok_d;
    out_first_q <= out_first_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign ok_o          = out_ok_q;
  assign first_index_o = $signed(out_first_q);

`ifndef NO_ASSERTIONS
  // no memory write while waiting for an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !ram_we)
    else $error("memory written while idle");

  // the word counter never passes the word count of the set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= n_q))
    else $error("scan counter overran word count");

  // an accepted beat moves the sequencer to decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted beat not decoded");

  // a result appears only from the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESULT))
    else $error("result loaded outside result state");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the multi bit-set engine.
module tb;
  import mbs_pkg::*;

  localparam int NumSets    = 4;
  localparam int MaxBits    = 1024;
  localparam int WordBits   = 32;
  localparam int CycleLimit = 500000;

  typedef struct packed {
    logic                   ok;
    logic signed [LenW-1:0] first_index;
  } set_outcome_t;

  // Clock, reset and block inputs, all known from time zero
  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic [OpW-1:0]     op_i          = '0;
  logic [SelW-1:0]    target_set_i  = '0;
  logic [SelW-1:0]    source_a_i    = '0;
  logic [SelW-1:0]    source_b_i    = '0;
  logic [BitIdxW-1:0] bit_index_i   = '0;
  logic               out_ready_i   = 1'b0;
  logic               cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i   = '0;
  logic [LenW-1:0]    cfg_data_i    = '0;

  logic                   in_ready_o;
  logic                   out_valid_o;
  logic                   ok_o;
  logic signed [LenW-1:0] first_index_o;
  logic                   cfg_ready_o;

  // Mirror of the set memory and the length registers
  logic [MaxBits-1:0] set_bits [NumSets];
  logic [LenW-1:0]    len_reg  [LenRegs];

  set_outcome_t pending_outcomes [$];
  int           fail_count     = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;

  multi_bitset_engine #(
    .NUM_SETS  (NumSets),
    .MAX_BITS  (MaxBits),
    .WORD_BITS (WordBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .target_set_i  (target_set_i),
    .source_a_i    (source_a_i),
    .source_b_i    (source_b_i),
    .bit_index_i   (bit_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .ok_o          (ok_o),
    .first_index_o (first_index_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Lengths above the set size act as the full set
  function automatic int eff_len(logic [SelW-1:0] s);
    return (len_reg[s] > MaxBits) ? MaxBits : int'(len_reg[s]);
  endfunction

  // Apply one operation to the mirror and return what the block should answer
  function automatic set_outcome_t apply_set_op(op_e op, logic [SelW-1:0] t,
                                                logic [SelW-1:0] a, logic [SelW-1:0] b,
                                                logic [BitIdxW-1:0] bit_idx);
    set_outcome_t     res;
    int               lt, la, lb, nw;
    logic [WordBits-1:0] wa, wb;
    res.ok = 1'b0;
    res.first_index = '0;
    lt = eff_len(t);
    la = eff_len(a);
    lb = eff_len(b);
    case (op)
      OP_INSERT, OP_REMOVE, OP_MEMBER: begin
        if (int'(bit_idx) < lt) begin
          if (op == OP_INSERT) begin
            set_bits[t][bit_idx] = 1'b1;
            res.ok = 1'b1;
          end else if (op == OP_REMOVE) begin
            set_bits[t][bit_idx] = 1'b0;
            res.ok = 1'b1;
          end else begin
            res.ok = set_bits[t][bit_idx];
          end
        end
      end
      OP_FIRST: begin
        res.first_index = '1;
        for (int i = 0; i < lt; i++) begin
          if (set_bits[t][i]) begin
            res.ok = 1'b1;
            res.first_index = LenW'(i);
            break;
          end
        end
      end
      OP_COPY: begin
        if (lt == la) begin
          nw = (lt + WordBits - 1) / WordBits;
          for (int w = 0; w < nw; w++)
            set_bits[t][w*WordBits +: WordBits] = set_bits[a][w*WordBits +: WordBits];
          res.ok = 1'b1;
        end
      end
      OP_UNION, OP_INTERSECT: begin
        if (lt == la && lt == lb) begin
          nw = (lt + WordBits - 1) / WordBits;
          for (int w = 0; w < nw; w++) begin
            wa = set_bits[a][w*WordBits +: WordBits];
            wb = set_bits[b][w*WordBits +: WordBits];
            set_bits[t][w*WordBits +: WordBits] = (op == OP_UNION) ? (wa | wb) : (wa & wb);
          end
          res.ok = 1'b1;
        end
      end
      default: begin
        if (la == lb) begin
          res.ok = 1'b1;
          for (int i = 0; i < la; i++) begin
            if (set_bits[a][i] != set_bits[b][i]) begin
              res.ok = 1'b0;
              break;
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    if (fail_count < 10) $display("%s", what);
    fail_count++;
  endtask

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : check_results
    set_outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("unexpected result ok=%b first_index=%0d",
                                  ok_o, first_index_o));
      end else begin
        want = pending_outcomes.pop_front();
        if (ok_o !== want.ok || first_index_o !== want.first_index)
          report_mismatch($sformatf(
            "result mismatch: expected ok=%b first_index=%0d, got ok=%b first_index=%0d",
            want.ok, $signed(want.first_index), ok_o, first_index_o));
      end
    end
  end

  // Send one item, idling at random first, and predict its result on accept
  task automatic issue_op(op_e op, logic [SelW-1:0] t, logic [SelW-1:0] a,
                          logic [SelW-1:0] b, logic [BitIdxW-1:0] bit_idx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    target_set_i <= t;
    source_a_i   <= a;
    source_b_i   <= b;
    bit_index_i  <= bit_idx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(apply_set_op(op, t, a, b, bit_idx));
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Write one length register; the block must be idle
  task automatic write_length_reg(logic [CfgIdxW-1:0] idx, logic [LenW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < LenRegs) len_reg[idx] = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Single-bit operations and first-member queries at the reset lengths, edges of the index range
  task automatic test_single_bits();
    issue_op(OP_FIRST,  2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_INSERT, 2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_INSERT, 2'd0, 2'd0, 2'd0, 12'd1023);
    issue_op(OP_INSERT, 2'd0, 2'd0, 2'd0, 12'd1024);
    issue_op(OP_INSERT, 2'd0, 2'd0, 2'd0, 12'd4095);
    issue_op(OP_MEMBER, 2'd0, 2'd0, 2'd0, 12'd1023);
    issue_op(OP_MEMBER, 2'd0, 2'd0, 2'd0, 12'd1022);
    issue_op(OP_FIRST,  2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_REMOVE, 2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_FIRST,  2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_REMOVE, 2'd0, 2'd0, 2'd0, 12'd4095);
  endtask

  // Inserts, then copy, union, intersect, equal and first on sets of matching length
  task automatic test_whole_sets();
    issue_op(OP_INSERT,    2'd1, 2'd0, 2'd0, 12'd31);
    issue_op(OP_INSERT,    2'd1, 2'd0, 2'd0, 12'd32);
    issue_op(OP_UNION,     2'd2, 2'd0, 2'd1, 12'd0);
    issue_op(OP_EQUAL,     2'd0, 2'd2, 2'd0, 12'd0);
    issue_op(OP_COPY,      2'd3, 2'd2, 2'd0, 12'd0);
    issue_op(OP_EQUAL,     2'd0, 2'd3, 2'd2, 12'd0);
    issue_op(OP_INTERSECT, 2'd3, 2'd3, 2'd1, 12'd0);
    issue_op(OP_FIRST,     2'd3, 2'd0, 2'd0, 12'd0);
  endtask

  // Zero, oversized and unequal lengths, unknown register indexes, stale bits
  task automatic test_length_limits();
    wait_results_drained();
    write_length_reg(4'd0, 11'd0);
    write_length_reg(4'd1, 11'd2047);
    write_length_reg(4'd2, 11'd33);
    write_length_reg(4'd3, 11'd1024);
    write_length_reg(4'd15, 11'd7);
    write_length_reg(4'd4, 11'd0);
    issue_op(OP_INSERT, 2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_FIRST,  2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_EQUAL,  2'd0, 2'd0, 2'd0, 12'd0);
    issue_op(OP_COPY,   2'd1, 2'd2, 2'd0, 12'd0);
    issue_op(OP_COPY,   2'd1, 2'd3, 2'd0, 12'd0);
    issue_op(OP_INSERT, 2'd2, 2'd0, 2'd0, 12'd33);
    issue_op(OP_FIRST,  2'd2, 2'd0, 2'd0, 12'd0);
    wait_results_drained();
    // shrink set two below its only members
    write_length_reg(4'd2, 11'd1);
    write_length_reg(4'd0, 11'd1);
    issue_op(OP_FIRST, 2'd2, 2'd0, 2'd0, 12'd0);
    issue_op(OP_EQUAL, 2'd0, 2'd0, 2'd2, 12'd0);
  endtask

  // Random traffic under one idling pattern and one length setting
  task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items, int common_len);
    int             pick, lt;
    op_e            op;
    logic [SelW-1:0]    t, a, b;
    logic [BitIdxW-1:0] bit_idx;
    wait_results_drained();
    for (int s = 0; s < LenRegs; s++) begin
      if ($urandom_range(2) == 0) write_length_reg(CfgIdxW'(s), LenW'($urandom_range(1024)));
      else write_length_reg(CfgIdxW'(s), LenW'(common_len));
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(99);
      if (pick < 28)      op = OP_INSERT;
      else if (pick < 38) op = OP_REMOVE;
      else if (pick < 52) op = OP_MEMBER;
      else if (pick < 62) op = OP_FIRST;
      else if (pick < 72) op = OP_COPY;
      else if (pick < 80) op = OP_UNION;
      else if (pick < 88) op = OP_INTERSECT;
      else                op = OP_EQUAL;
      t  = SelW'($urandom_range(NumSets - 1));
      a  = SelW'($urandom_range(NumSets - 1));
      b  = SelW'($urandom_range(NumSets - 1));
      lt = eff_len(t);
      if (lt > 0 && $urandom_range(99) < 88) bit_idx = BitIdxW'($urandom_range(lt - 1));
      else bit_idx = BitIdxW'($urandom_range(4095));
      issue_op(op, t, a, b, bit_idx);
    end
    wait_results_drained();
  endtask

  initial begin : run_tests
    for (int s = 0; s < NumSets; s++) set_bits[s] = '0;
    for (int r = 0; r < LenRegs; r++) len_reg[r] = LenReset;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_single_bits();
    test_whole_sets();
    test_length_limits();
    test_random_traffic(0, 0, 175, 1024);
    test_random_traffic(49, 0, 175, $urandom_range(1, 1024));
    test_random_traffic(0, 49, 175, 32);
    test_random_traffic(28, 28, 175, $urandom_range(1, 1024));

    // let the last results settle before judging
    repeat (64) @(posedge clk_i);
    if (fail_count == 0 && pending_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mbs_pkg.sv
rtl/mbs_ram.sv
rtl/multi_bitset_engine.sv
tb/sv/tb.sv
